@@ rtl/spam_pkg.sv @@
`default_nettype none
package spam_pkg;

	// store sizing
	localparam int MAX_TERMS  = 16;
	localparam int RESULT_CAP = 32;
	localparam int IDX_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W      = $clog2(MAX_TERMS + 1);
	localparam int RES_W      = $clog2(RESULT_CAP + 1);

	// field widths
	localparam int COEFF_W  = 16;
	localparam int POWER_W  = 10;
	localparam int SUM_W    = COEFF_W + 1;
	localparam int TERM_W   = COEFF_W + POWER_W;

	// request op codes
	typedef enum logic [1:0] {
		OP_LOAD_FIRST  = 2'd0,
		OP_LOAD_SECOND = 2'd1,
		OP_MERGE       = 2'd2,
		OP_NONE        = 2'd3
	} op_t;

	// one stored term
	typedef struct packed {
		logic signed [COEFF_W-1:0] coeff;
		logic        [POWER_W-1:0] power;
	} term_t;

	// one merge step from the shared unit
	typedef struct packed {
		logic                    take_first;
		logic                    take_second;
		logic signed [SUM_W-1:0] coeff;
		logic [POWER_W-1:0]      power;
	} step_t;

	// merge sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

@@ rtl/spam_ram.sv @@
`default_nettype none
module spam_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                   clk,
	input  wire logic                   wr_en,
	input  wire logic [AW-1:0]          wr_addr,
	input  wire logic [WIDTH-1:0]       wr_data,
	input  wire logic [AW-1:0]          rd_addr,
	output logic      [WIDTH-1:0]       rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;
endmodule
`default_nettype wire

@@ rtl/spam_unit.sv @@
`default_nettype none
module spam_unit (
	input  wire logic            avail_first,
	input  wire logic            avail_second,
	input  wire spam_pkg::term_t term_first,
	input  wire spam_pkg::term_t term_second,
	output spam_pkg::step_t      step
);
	import spam_pkg::*;

	logic signed [SUM_W-1:0] ext_first;
	logic signed [SUM_W-1:0] ext_second;

	assign ext_first  = SUM_W'(term_first.coeff);
	assign ext_second = SUM_W'(term_second.coeff);

	// exponent compare and coefficient add for one merge step
	always_comb begin
		step.take_first  = 1'b0;
		step.take_second = 1'b0;
		step.coeff       = ext_second;
		step.power       = term_second.power;
		if (avail_first && avail_second) begin
			if (term_first.power > term_second.power) begin
				step.take_first = 1'b1;
				step.coeff      = ext_first;
				step.power      = term_first.power;
			end else if (term_first.power < term_second.power) begin
				step.take_second = 1'b1;
			end else begin
				// equal exponents: one term, coefficients summed
				step.take_first  = 1'b1;
				step.take_second = 1'b1;
				step.coeff       = ext_first + ext_second;
				step.power       = term_first.power;
			end
		end else if (avail_first) begin
			step.take_first = 1'b1;
			step.coeff      = ext_first;
			step.power      = term_first.power;
		end else begin
			step.take_second = avail_second;
		end
	end
endmodule
`default_nettype wire

@@ rtl/sparse_polynomial_add_merge.sv @@
// Sparse polynomial adder by sorted merge.
// Input channel (in_valid/in_ready) carries requests: op 0 loads a term
// (coeff_in, power_in) into the first store, op 1 into the second, op 2
// starts a merge, op 3 is ignored. Each store holds MAX_TERMS terms, which
// must be loaded in descending exponent order; the block does not enforce
// this. A load into a full store is discarded and flags dropped on every
// term of the next merge. A merge gives up to 2 * MAX_TERMS result terms;
// for each it reads the stores, then compares and adds in the shared unit;
// the read is a separate step, as each store has a registered read port.
// No request is taken while a merge runs.
// Output channel (out_valid/out_ready) gives one term per result, last on
// the final one; a merge of two empty stores gives no result. A stalled
// receiver holds the merge in place; the output register lets the next
// request be taken while the final term still waits.
// Reset empties both stores and clears the drop flag.
`default_nettype none
module sparse_polynomial_add_merge (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [1:0]                      op,
	input  wire logic signed [spam_pkg::COEFF_W-1:0] coeff_in,
	input  wire logic [spam_pkg::POWER_W-1:0]    power_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [spam_pkg::SUM_W-1:0]    coeff_out,
	output logic [spam_pkg::POWER_W-1:0]         power_out,
	output logic                                 last,
	output logic                                 dropped
);
	import spam_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic [CNT_W-1:0] idx_a_q, idx_b_q;
	logic [CNT_W-1:0] idx_a_nx, idx_b_nx;
	logic [RES_W-1:0] n_q;
	logic             ovf_q;

	logic             out_valid_q;
	logic signed [SUM_W-1:0] coeff_q;
	logic [POWER_W-1:0] power_q;
	logic             last_q;
	logic             dropped_q;

	logic accept, full_a, full_b, wr_a, wr_b, ovf_set, start, both_empty;
	logic emit, done, avail_a, avail_b;

	logic [TERM_W-1:0] rd_a, rd_b;
	term_t             wr_term;
	step_t             step;

	assign wr_term.coeff = coeff_in;
	assign wr_term.power = power_in;

	// term stores
	spam_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_store_first (
		.clk     (clk),
		.wr_en   (wr_a),
		.wr_addr (cnt_a_q[IDX_W-1:0]),
		.wr_data (wr_term),
		.rd_addr (idx_a_q[IDX_W-1:0]),
		.rd_data (rd_a)
	);

	spam_ram #(.WIDTH(TERM_W), .DEPTH(MAX_TERMS)) u_store_second (
		.clk     (clk),
		.wr_en   (wr_b),
		.wr_addr (cnt_b_q[IDX_W-1:0]),
		.wr_data (wr_term),
		.rd_addr (idx_b_q[IDX_W-1:0]),
		.rd_data (rd_b)
	);

	// shared compare/add unit
	assign avail_a = idx_a_q < cnt_a_q;
	assign avail_b = idx_b_q < cnt_b_q;

	spam_unit u_unit (
		.avail_first  (avail_a),
		.avail_second (avail_b),
		.term_first   (term_t'(rd_a)),
		.term_second  (term_t'(rd_b)),
		.step         (step)
	);

	assign idx_a_nx = idx_a_q + CNT_W'(step.take_first);
	assign idx_b_nx = idx_b_q + CNT_W'(step.take_second);

	// sequencer: next state and strobes
	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		accept     = in_valid && in_ready;
		full_a     = (cnt_a_q >= CNT_W'(MAX_TERMS));
		full_b     = (cnt_b_q >= CNT_W'(MAX_TERMS));
		wr_a       = accept && (op == OP_LOAD_FIRST) && !full_a;
		wr_b       = accept && (op == OP_LOAD_SECOND) && !full_b;
		ovf_set    = accept && (((op == OP_LOAD_FIRST) && full_a) ||
		                        ((op == OP_LOAD_SECOND) && full_b));
		start      = accept && (op == OP_MERGE);
		both_empty = (cnt_a_q == '0) && (cnt_b_q == '0);
		emit       = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		done       = ((idx_a_nx >= cnt_a_q) && (idx_b_nx >= cnt_b_q)) ||
		             (n_q == RES_W'(RESULT_CAP - 1));
		state_d    = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && !both_empty) begin
					state_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit) begin
					state_d = done ? ST_IDLE : ST_FETCH;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// store counts, merge indices and drop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q <= '0;
			cnt_b_q <= '0;
			idx_a_q <= '0;
			idx_b_q <= '0;
			n_q     <= '0;
			ovf_q   <= 1'b0;
		end else begin
			if (wr_a) begin
				cnt_a_q <= cnt_a_q + CNT_W'(1);
			end
			if (wr_b) begin
				cnt_b_q <= cnt_b_q + CNT_W'(1);
			end
			if (ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (start) begin
				idx_a_q <= '0;
				idx_b_q <= '0;
				n_q     <= '0;
				if (both_empty) begin
					ovf_q <= 1'b0;
				end
			end
			if (emit) begin
				idx_a_q <= idx_a_nx;
				idx_b_q <= idx_b_nx;
				n_q     <= n_q + RES_W'(1);
				if (done) begin
					cnt_a_q <= '0;
					cnt_b_q <= '0;
					ovf_q   <= 1'b0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			coeff_q   <= step.coeff;
			power_q   <= step.power;
			last_q    <= done;
			dropped_q <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign coeff_out = coeff_q;
	assign power_out = power_q;
	assign last      = last_q;
	assign dropped   = dropped_q;
endmodule
`default_nettype wire

@@ bench/sparse_polynomial_add_merge_tb.sv @@
`default_nettype none
module sparse_polynomial_add_merge_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import spam_pkg::*;

	localparam int N_ITEMS      = 410;
	localparam int IDLE_PCT     = 37;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 4 * RESULT_CAP + 20;
	localparam int SHOW_MAX     = 10;

	// one merged output term
	typedef struct packed {
		logic signed [SUM_W-1:0] coeff;
		logic [POWER_W-1:0]      power;
		logic                    last;
		logic                    dropped;
	} sum_term_t;

	// one directed request; typed rows carry their single expected term
	typedef struct packed {
		op_t                       op;
		logic signed [COEFF_W-1:0] coeff;
		logic [POWER_W-1:0]        power;
		logic                      typed;
		logic signed [SUM_W-1:0]   t_coeff;
		logic [POWER_W-1:0]        t_power;
	} stim_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                op;
	logic signed [COEFF_W-1:0] coeff_in;
	logic [POWER_W-1:0]        power_in;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [SUM_W-1:0]   coeff_out;
	logic [POWER_W-1:0]        power_out;
	logic                      last;
	logic                      dropped;

	// mirror of the two term stores
	term_t     first_terms [MAX_TERMS];
	term_t     second_terms [MAX_TERMS];
	int        first_count;
	int        second_count;
	logic      drop_seen;

	sum_term_t sum_terms_q [$];
	stim_row_t dir_rows [$];
	int        items_sent;
	int        fails;
	int        idle_cycles = 0;
	logic      calm;

	sparse_polynomial_add_merge u_top (.*);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver stalls, none while calm
	always @(negedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	task automatic note_fail(input string msg);
		fails++;
		if (fails <= SHOW_MAX) begin
			$display("%s", msg);
		end
	endtask

	// predictor: apply one accepted request, queue the terms it yields
	task automatic add_polys_step(input op_t o, input logic signed [COEFF_W-1:0] c,
			input logic [POWER_W-1:0] p);
		term_t                   t;
		term_t                   a;
		term_t                   b;
		sum_term_t               pend;
		logic                    have_pend;
		int                      i;
		int                      j;
		int                      n;
		logic signed [SUM_W-1:0] ca;
		logic signed [SUM_W-1:0] cb;
		t.coeff = c;
		t.power = p;
		case (o)
			OP_LOAD_FIRST: begin
				if (first_count >= MAX_TERMS) begin
					drop_seen = 1'b1;
				end else begin
					first_terms[first_count] = t;
					first_count++;
				end
			end
			OP_LOAD_SECOND: begin
				if (second_count >= MAX_TERMS) begin
					drop_seen = 1'b1;
				end else begin
					second_terms[second_count] = t;
					second_count++;
				end
			end
			OP_MERGE: begin
				i = 0;
				j = 0;
				n = 0;
				have_pend = 1'b0;
				while ((i < first_count || j < second_count) && n < RESULT_CAP) begin
					if (i < first_count) a = first_terms[i];
					if (j < second_count) b = second_terms[j];
					ca = a.coeff;
					cb = b.coeff;
					if (have_pend) sum_terms_q.push_back(pend);
					pend.last    = 1'b0;
					pend.dropped = drop_seen;
					if (i < first_count && j < second_count && a.power == b.power) begin
						// equal exponents: one term, coefficients summed
						pend.coeff = ca + cb;
						pend.power = a.power;
						i++;
						j++;
					end else if (i < first_count && (j >= second_count || a.power > b.power)) begin
						pend.coeff = ca;
						pend.power = a.power;
						i++;
					end else begin
						pend.coeff = cb;
						pend.power = b.power;
						j++;
					end
					have_pend = 1'b1;
					n++;
				end
				if (have_pend) begin
					pend.last = 1'b1;
					sum_terms_q.push_back(pend);
				end
				first_count  = 0;
				second_count = 0;
				drop_seen    = 1'b0;
			end
			default: ;
		endcase
	endtask

	// drive one request at the falling edge, hold it until taken
	task automatic send_req(input op_t o, input logic signed [COEFF_W-1:0] c,
			input logic [POWER_W-1:0] p);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		coeff_in <= c;
		power_in <= p;
		do @(posedge clk); while (!in_ready);
		add_polys_step(o, c, p);
		if (o != OP_NONE) items_sent++;
		@(negedge clk);
	endtask

	task automatic add_row(input op_t o, input logic signed [COEFF_W-1:0] c,
			input logic [POWER_W-1:0] p, input logic typed,
			input logic signed [SUM_W-1:0] tc, input logic [POWER_W-1:0] tp);
		stim_row_t r;
		r.op      = o;
		r.coeff   = c;
		r.power   = p;
		r.typed   = typed;
		r.t_coeff = tc;
		r.t_power = tp;
		dir_rows.push_back(r);
	endtask

	function automatic logic signed [COEFF_W-1:0] pick_coeff();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return COEFF_W'(int'($urandom_range(0, 4)) - 2);
			default: return COEFF_W'($urandom);
		endcase
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return $urandom_range(0, 5);
		if (r < 8) return $urandom_range(6, 13);
		return $urandom_range(14, 19);
	endfunction

	// two polynomials, descending unless jumbled, with overlapping exponents; loads interleaved, then a merge
	task automatic random_pair(input int nf, input int ns);
		int pf [20];
		int ps [20];
		int a;
		int b;
		int v;
		int hi;
		int stride;
		bit jumbled;
		jumbled = ($urandom_range(0, 7) == 0);
		hi      = $urandom_range(0, 1023);
		stride  = $urandom_range(1, 3);
		for (a = 0; a < nf; a++) begin
			v     = jumbled ? int'($urandom_range(0, 1023)) : hi - a * stride;
			pf[a] = (v < 0) ? int'($urandom_range(0, 1023)) : v;
		end
		hi     = hi - int'($urandom_range(0, 6));
		stride = $urandom_range(1, 3);
		for (b = 0; b < ns; b++) begin
			v     = jumbled ? int'($urandom_range(0, 1023)) : hi - b * stride;
			ps[b] = (v < 0) ? int'($urandom_range(0, 1023)) : v;
		end
		a = 0;
		b = 0;
		while (a < nf || b < ns) begin
			if ($urandom_range(0, 24) == 0) begin
				send_req(OP_NONE, COEFF_W'($urandom), POWER_W'($urandom));
			end
			if (a < nf && (b >= ns || $urandom_range(0, 1) == 1)) begin
				send_req(OP_LOAD_FIRST, pick_coeff(), POWER_W'(pf[a]));
				a++;
			end else begin
				send_req(OP_LOAD_SECOND, pick_coeff(), POWER_W'(ps[b]));
				b++;
			end
		end
		send_req(OP_MERGE, COEFF_W'($urandom), POWER_W'($urandom));
	endtask

	// check each output term against the oldest expectation
	always @(posedge clk) begin
		sum_term_t want;
		sum_term_t got;
		if (arst_n && out_valid && out_ready) begin
			got.coeff   = coeff_out;
			got.power   = power_out;
			got.last    = last;
			got.dropped = dropped;
			if (sum_terms_q.size() == 0) begin
				note_fail($sformatf("unexpected term: coeff %0d power %0d last %0b dropped %0b",
					got.coeff, got.power, got.last, got.dropped));
			end else begin
				want = sum_terms_q.pop_front();
				if (got.coeff !== want.coeff || got.power !== want.power ||
						got.last !== want.last || got.dropped !== want.dropped) begin
					note_fail($sformatf({"term mismatch: expected coeff %0d power %0d last %0b ",
						"dropped %0b, got coeff %0d power %0d last %0b dropped %0b"},
						want.coeff, want.power, want.last, want.dropped,
						got.coeff, got.power, got.last, got.dropped));
				end
			end
		end
	end

	// watchdog on cycles with no request or term taken
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sparse_polynomial_add_merge_tb NOT OK");
			$finish;
		end
	end

	initial begin
		sum_term_t typed_term;
		int        nf;
		int        ns;
		int        seq_no;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		op           = OP_NONE;
		coeff_in     = '0;
		power_in     = '0;
		out_ready    = 1'b0;
		calm         = 1'b0;
		items_sent   = 0;
		fails        = 0;
		first_count  = 0;
		second_count = 0;
		drop_seen    = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed requests: op, coeff, power, typed, expected coeff, expected power
		// typed terms are the only term of their merge: last set, dropped clear
		add_row(OP_MERGE,       16'sd0,      10'd0,   1'b0, 17'sd0,      10'd0);
		add_row(OP_LOAD_FIRST,  16'sh7fff,   10'd1023, 1'b0, 17'sd0,     10'd0);
		add_row(OP_LOAD_SECOND, 16'sh7fff,   10'd1023, 1'b0, 17'sd0,     10'd0);
		add_row(OP_MERGE,       16'sd0,      10'd0,   1'b1, 17'sd65534,  10'd1023);
		add_row(OP_LOAD_FIRST,  16'sh8000,   10'd0,   1'b0, 17'sd0,      10'd0);
		add_row(OP_LOAD_SECOND, 16'sh8000,   10'd0,   1'b0, 17'sd0,      10'd0);
		add_row(OP_MERGE,       16'sh7fff,   10'd1023, 1'b1, -17'sd65536, 10'd0);
		add_row(OP_NONE,        16'sh5a5a,   10'h2a5, 1'b0, 17'sd0,      10'd0);
		add_row(OP_LOAD_FIRST,  16'sd5,      10'd7,   1'b0, 17'sd0,      10'd0);
		add_row(OP_LOAD_SECOND, -16'sd5,     10'd7,   1'b0, 17'sd0,      10'd0);
		add_row(OP_MERGE,       16'sd0,      10'd0,   1'b1, 17'sd0,      10'd7);
		add_row(OP_LOAD_FIRST,  16'sd100,    10'd3,   1'b0, 17'sd0,      10'd0);
		add_row(OP_MERGE,       16'sd0,      10'd0,   1'b1, 17'sd100,    10'd3);
		add_row(OP_LOAD_SECOND, -16'sd1,     10'd512, 1'b0, 17'sd0,      10'd0);
		add_row(OP_MERGE,       16'sd0,      10'd0,   1'b1, -17'sd1,     10'd512);
		// unsorted first store, mixed merge
		add_row(OP_LOAD_FIRST,  16'sd1,      10'd2,   1'b0, 17'sd0,      10'd0);
		add_row(OP_LOAD_FIRST,  16'sd3,      10'd9,   1'b0, 17'sd0,      10'd0);
		add_row(OP_LOAD_SECOND, 16'sd4,      10'd5,   1'b0, 17'sd0,      10'd0);
		add_row(OP_LOAD_SECOND, 16'sd6,      10'd2,   1'b0, 17'sd0,      10'd0);
		add_row(OP_NONE,        16'sh8000,   10'h15a, 1'b0, 17'sd0,      10'd0);
		add_row(OP_MERGE,       16'shffff,   10'h3ff, 1'b0, 17'sd0,      10'd0);

		foreach (dir_rows[k]) begin
			send_req(dir_rows[k].op, dir_rows[k].coeff, dir_rows[k].power);
			if (dir_rows[k].typed) begin
				typed_term.coeff   = dir_rows[k].t_coeff;
				typed_term.power   = dir_rows[k].t_power;
				typed_term.last    = 1'b1;
				typed_term.dropped = 1'b0;
				void'(sum_terms_q.pop_back());
				sum_terms_q.push_back(typed_term);
			end
		end

		// random polynomial pairs; the first overflows both stores, the second fills them
		seq_no = 0;
		while (items_sent < N_ITEMS) begin
			calm = (items_sent >= 150 && items_sent < 260);
			if (seq_no == 0) begin
				nf = 18;
				ns = 17;
			end else if (seq_no == 1) begin
				nf = MAX_TERMS;
				ns = MAX_TERMS;
			end else begin
				nf = pick_count();
				ns = pick_count();
			end
			random_pair(nf, ns);
			seq_no++;
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// let the last terms drain, then look for strays
		while (sum_terms_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("sparse_polynomial_add_merge_tb OK");
		end else begin
			$display("sparse_polynomial_add_merge_tb NOT OK");
		end
		$finish;
	end

endmodule
`default_nettype wire
